/* rtl/qrvs_pkg.sv */
// shared types and constants of the quadratic root and vertex solver
package qrvs_pkg;

	// root kind codes
	localparam logic [1:0] KIND_TWO     = 2'd0;
	localparam logic [1:0] KIND_DOUBLE  = 2'd1;
	localparam logic [1:0] KIND_COMPLEX = 2'd2;
	localparam logic [1:0] KIND_AZERO   = 2'd3;

	// datapath widths
	localparam int COEF_W  = 32;
	localparam int RAD_W   = 66;  // discriminant magnitude
	localparam int ROOT_W  = 33;  // floor sqrt of the discriminant
	localparam int SREM_W  = 34;  // square root partial remainder
	localparam int DIV_W   = 63;  // dividend and quotient
	localparam int DEN_W   = 34;  // divisor and division remainder
	localparam int NMAG_W  = 34;  // numerator magnitude before scaling
	localparam int N_LANES = 4;

	// division lanes
	localparam int LANE_PLUS  = 0;
	localparam int LANE_MINUS = 1;
	localparam int LANE_VX    = 2;
	localparam int LANE_VY    = 3;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_state_t;

	typedef struct packed {
		logic                     a_zero;
		logic                     a_neg;
		logic [COEF_W-1:0]        a_mag;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic                     dneg;
		logic                     dzero;
		logic [DIV_W-1:0]         b2;
	} sq_side_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		logic                     a_zero;
		logic [1:0]               kind;
		logic                     dneg;
		logic signed [COEF_W-1:0] c;
	} div_side_t;

endpackage

/* rtl/qrvs_coef_if.sv */
// request channel carrying one coefficient set
interface qrvs_coef_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] coef_a;
	logic signed [31:0] coef_b;
	logic signed [31:0] coef_c;

	modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* rtl/qrvs_result_if.sv */
// result channel carrying roots, vertex and flags
interface qrvs_result_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  root_kind;
	logic signed [31:0] root_plus;
	logic signed [31:0] root_minus;
	logic signed [31:0] imag_part;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic               saturated;

	modport source(output valid, output root_kind, output root_plus, output root_minus,
		output imag_part, output vertex_x, output vertex_y, output saturated, input ready);
	modport sink(input valid, input root_kind, input root_plus, input root_minus,
		input imag_part, input vertex_x, input vertex_y, input saturated, output ready);
endinterface

/* rtl/qrvs_sqrt_cell.sv */
// one restoring square root step, two radicand bits per cell
module qrvs_sqrt_cell import qrvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      prev_vld,
	input  sq_state_t prev_st,
	input  sq_side_t  prev_side,
	output logic      vld,
	output sq_state_t st,
	output sq_side_t  side
);

	logic [SREM_W+1:0] acc;
	logic [SREM_W:0]   trial;
	logic              fits;
	sq_state_t         nxt;

	// bring down two bits and try root*4+1
	always_comb begin
		acc   = {prev_st.rem, prev_st.rad[RAD_W-1 -: 2]};
		trial = {prev_st.root, 2'b01};
		fits  = acc >= {1'b0, trial};
		nxt.rad = {prev_st.rad[RAD_W-3:0], 2'b00};
		if (fits) begin
			nxt.rem  = SREM_W'(acc - {1'b0, trial});
			nxt.root = {prev_st.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc[SREM_W-1:0];
			nxt.root = {prev_st.root[ROOT_W-2:0], 1'b0};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= prev_vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			st   <= nxt;
			side <= prev_side;
		end
	end

endmodule

/* rtl/qrvs_div_cell.sv */
// one restoring division step on each of the four quotient lanes
module qrvs_div_cell import qrvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      prev_vld,
	input  div_lane_t prev_lane [N_LANES],
	input  div_side_t prev_side,
	output logic      vld,
	output div_lane_t lane [N_LANES],
	output div_side_t side
);

	div_lane_t nxt [N_LANES];

	// shift in one dividend bit, subtract divisor where it fits
	always_comb begin
		for (int i = 0; i < N_LANES; i++) begin
			logic [DEN_W:0] t;
			logic           ge;
			t  = {prev_lane[i].rem, prev_lane[i].num[DIV_W-1]};
			ge = t >= {1'b0, prev_lane[i].den};
			nxt[i].den = prev_lane[i].den;
			nxt[i].neg = prev_lane[i].neg;
			nxt[i].num = {prev_lane[i].num[DIV_W-2:0], ge};
			nxt[i].rem = ge ? DEN_W'(t - {1'b0, prev_lane[i].den}) : t[DEN_W-1:0];
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= prev_vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			lane <= nxt;
			side <= prev_side;
		end
	end

endmodule

/* rtl/quadratic_root_vertex_solver.sv */
// throughput: one request per cycle while the pipeline is not held; 3 front stages, 33 square root cells,
// one setup stage, 63 division cells and the output register
// the whole pipeline holds while a result waits and the sink is not ready
// reset clears every valid bit; payload registers are not reset
module quadratic_root_vertex_solver import qrvs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qrvs_coef_if.sink            coef,
	qrvs_result_if.source        result
);

	localparam int N_SQ  = ROOT_W;
	localparam int N_DIV = DIV_W;

	logic en;

	// clip a signed quotient to 32 bits, flag in the top bit
	function automatic logic [COEF_W:0] clip_q(input logic [DIV_W-1:0] q, input logic neg);
		logic [COEF_W:0] r;
		if (!neg && q > DIV_W'(32'h7fff_ffff)) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (neg && q > DIV_W'(33'h0_8000_0000)) begin
			r = {1'b1, 32'h8000_0000};
		end else if (neg) begin
			r = {1'b0, 32'(~q + 1'b1)};
		end else begin
			r = {1'b0, q[COEF_W-1:0]};
		end
		return r;
	endfunction

	// whole pipeline advances when the output slot is free or taken
	assign en         = !result.valid || result.ready;
	assign coef.ready = en;

	// stage 1: capture the request
	logic                     vld_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef.coef_a;
			b_s1 <= coef.coef_b;
			c_s1 <= coef.coef_c;
		end
	end

	// stage 2: magnitudes and the two products
	logic [COEF_W-1:0]        am, bm, cm;
	logic                     vld_s2, a_neg_s2, c_neg_s2;
	logic [COEF_W-1:0]        a_mag_s2;
	logic signed [COEF_W-1:0] b_s2, c_s2;
	logic [2*COEF_W-1:0]      b2_s2, p_s2;

	assign am = a_s1[COEF_W-1] ? COEF_W'(-a_s1) : a_s1;
	assign bm = b_s1[COEF_W-1] ? COEF_W'(-b_s1) : b_s1;
	assign cm = c_s1[COEF_W-1] ? COEF_W'(-c_s1) : c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_neg_s2 <= a_s1[COEF_W-1];
			c_neg_s2 <= c_s1[COEF_W-1];
			a_mag_s2 <= am;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			b2_s2    <= bm * bm;
			p_s2     <= am * cm;
		end
	end

	// stage 3: discriminant magnitude and sign
	logic [RAD_W-1:0] d_sum;
	logic [RAD_W:0]   d_diff;
	logic             same_sign;
	sq_state_t        st_nx;
	sq_side_t         side_nx;
	logic             vld_s3;
	sq_state_t        st_s3;
	sq_side_t         side_s3;

	always_comb begin
		d_sum     = {2'b00, b2_s2} + {p_s2, 2'b00};
		d_diff    = {3'b000, b2_s2} - {1'b0, p_s2, 2'b00};
		same_sign = (a_neg_s2 == c_neg_s2) && (p_s2 != '0);
		side_nx.a_zero = (a_mag_s2 == '0);
		side_nx.a_neg  = a_neg_s2;
		side_nx.a_mag  = a_mag_s2;
		side_nx.b      = b_s2;
		side_nx.c      = c_s2;
		side_nx.b2     = b2_s2[DIV_W-1:0];
		st_nx.rem      = '0;
		st_nx.root     = '0;
		if (!same_sign) begin
			st_nx.rad    = d_sum;
			side_nx.dneg = 1'b0;
		end else if (!d_diff[RAD_W]) begin
			st_nx.rad    = d_diff[RAD_W-1:0];
			side_nx.dneg = 1'b0;
		end else begin
			st_nx.rad    = RAD_W'(-d_diff);
			side_nx.dneg = 1'b1;
		end
		side_nx.dzero = (st_nx.rad == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3   <= st_nx;
			side_s3 <= side_nx;
		end
	end

	// square root chain
	logic      sq_vld  [N_SQ+1];
	sq_state_t sq_st   [N_SQ+1];
	sq_side_t  sq_side [N_SQ+1];

	assign sq_vld[0]  = vld_s3;
	assign sq_st[0]   = st_s3;
	assign sq_side[0] = side_s3;

	for (genvar i = 0; i < N_SQ; i++) begin : g_sq
		qrvs_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.prev_vld  (sq_vld[i]),
			.prev_st   (sq_st[i]),
			.prev_side (sq_side[i]),
			.vld       (sq_vld[i+1]),
			.st        (sq_st[i+1]),
			.side      (sq_side[i+1])
		);
	end

	// setup stage: numerators, divisors and quotient signs
	sq_side_t           sd;
	logic signed [34:0] nb, s35, n1, n2;
	logic [NMAG_W-1:0]  m1, m2, m3;
	logic [DEN_W-1:0]   den2a;
	div_lane_t          lane_nx [N_LANES];
	div_side_t          dside_nx;
	logic               vld_s4;
	div_lane_t          lane_s4 [N_LANES];
	div_side_t          dside_s4;

	always_comb begin
		sd    = sq_side[N_SQ];
		nb    = -35'(sd.b);
		s35   = 35'(sq_st[N_SQ].root);
		n1    = sd.dneg ? nb : nb + s35;
		n2    = sd.dneg ? s35 : nb - s35;
		m1    = n1[34] ? NMAG_W'(-n1) : n1[NMAG_W-1:0];
		m2    = n2[34] ? NMAG_W'(-n2) : n2[NMAG_W-1:0];
		m3    = nb[34] ? NMAG_W'(-nb) : nb[NMAG_W-1:0];
		den2a = {1'b0, sd.a_mag, 1'b0};

		lane_nx[LANE_PLUS].num  = DIV_W'(m1) << FRAC_BITS;
		lane_nx[LANE_PLUS].den  = den2a;
		lane_nx[LANE_PLUS].neg  = n1[34] ^ sd.a_neg;
		lane_nx[LANE_MINUS].num = DIV_W'(m2) << FRAC_BITS;
		lane_nx[LANE_MINUS].den = den2a;
		lane_nx[LANE_MINUS].neg = !sd.dneg && (n2[34] ^ sd.a_neg);
		lane_nx[LANE_VX].num    = DIV_W'(m3) << FRAC_BITS;
		lane_nx[LANE_VX].den    = den2a;
		lane_nx[LANE_VX].neg    = nb[34] ^ sd.a_neg;
		// b*b / 4|a|, neg marks that it is added to c
		lane_nx[LANE_VY].num    = sd.b2;
		lane_nx[LANE_VY].den    = {sd.a_mag, 2'b00};
		lane_nx[LANE_VY].neg    = sd.a_neg;
		for (int i = 0; i < N_LANES; i++) begin
			lane_nx[i].rem = '0;
		end

		dside_nx.a_zero = sd.a_zero;
		dside_nx.dneg   = sd.dneg;
		dside_nx.c      = sd.c;
		if (sd.a_zero) begin
			dside_nx.kind = KIND_AZERO;
		end else if (sd.dneg) begin
			dside_nx.kind = KIND_COMPLEX;
		end else if (sd.dzero) begin
			dside_nx.kind = KIND_DOUBLE;
		end else begin
			dside_nx.kind = KIND_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld[N_SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s4  <= lane_nx;
			dside_s4 <= dside_nx;
		end
	end

	// division chain
	logic      dv_vld  [N_DIV+1];
	div_lane_t dv_lane [N_DIV+1][N_LANES];
	div_side_t dv_side [N_DIV+1];

	assign dv_vld[0]  = vld_s4;
	assign dv_lane[0] = lane_s4;
	assign dv_side[0] = dside_s4;

	for (genvar i = 0; i < N_DIV; i++) begin : g_div
		qrvs_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.prev_vld  (dv_vld[i]),
			.prev_lane (dv_lane[i]),
			.prev_side (dv_side[i]),
			.vld       (dv_vld[i+1]),
			.lane      (dv_lane[i+1]),
			.side      (dv_side[i+1])
		);
	end

	// output stage: signs, vertex y, saturation and selection
	div_side_t               fs;
	logic [COEF_W:0]         r_plus, r_minus, r_vx;
	logic signed [63:0]      vy_full;
	logic [DIV_W-1:0]        q_vy;
	logic                    vy_clip;
	logic [COEF_W-1:0]       vy_val;
	logic [1:0]              kind_nx;
	logic [COEF_W-1:0]       rp_nx, rm_nx, im_nx, vx_nx, vy_nx;
	logic                    sat_nx;
	logic                    vld_q;
	logic [1:0]              kind_q;
	logic [COEF_W-1:0]       rp_q, rm_q, im_q, vx_q, vy_q;
	logic                    sat_q;

	always_comb begin
		fs      = dv_side[N_DIV];
		r_plus  = clip_q(dv_lane[N_DIV][LANE_PLUS].num, dv_lane[N_DIV][LANE_PLUS].neg);
		r_minus = clip_q(dv_lane[N_DIV][LANE_MINUS].num, dv_lane[N_DIV][LANE_MINUS].neg);
		r_vx    = clip_q(dv_lane[N_DIV][LANE_VX].num, dv_lane[N_DIV][LANE_VX].neg);
		q_vy    = dv_lane[N_DIV][LANE_VY].num;
		if (dv_lane[N_DIV][LANE_VY].neg) begin
			vy_full = 64'(fs.c) + $signed({1'b0, q_vy});
		end else begin
			vy_full = 64'(fs.c) - $signed({1'b0, q_vy});
		end
		vy_clip = (vy_full[63:31] != '0) && (vy_full[63:31] != '1);
		if (!vy_clip) begin
			vy_val = vy_full[COEF_W-1:0];
		end else if (vy_full[63]) begin
			vy_val = 32'h8000_0000;
		end else begin
			vy_val = 32'h7fff_ffff;
		end

		kind_nx = fs.kind;
		if (fs.a_zero) begin
			rp_nx  = '0;
			rm_nx  = '0;
			im_nx  = '0;
			vx_nx  = '0;
			vy_nx  = '0;
			sat_nx = 1'b0;
		end else begin
			rp_nx  = r_plus[COEF_W-1:0];
			rm_nx  = fs.dneg ? '0 : r_minus[COEF_W-1:0];
			im_nx  = fs.dneg ? r_minus[COEF_W-1:0] : '0;
			vx_nx  = r_vx[COEF_W-1:0];
			vy_nx  = vy_val;
			sat_nx = r_plus[COEF_W] | r_minus[COEF_W] | r_vx[COEF_W] | vy_clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld[N_DIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= kind_nx;
			rp_q   <= rp_nx;
			rm_q   <= rm_nx;
			im_q   <= im_nx;
			vx_q   <= vx_nx;
			vy_q   <= vy_nx;
			sat_q  <= sat_nx;
		end
	end

	// result port
	assign result.valid      = vld_q;
	assign result.root_kind  = kind_q;
	assign result.root_plus  = rp_q;
	assign result.root_minus = rm_q;
	assign result.imag_part  = im_q;
	assign result.vertex_x   = vx_q;
	assign result.vertex_y   = vy_q;
	assign result.saturated  = sat_q;

endmodule

/* rtl/qrvs_checker.sv */
// port level checks of the solver result channel, bound to the top level
module qrvs_checker import qrvs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic        [1:0]  root_kind,
	input logic signed [31:0] root_plus,
	input logic signed [31:0] root_minus,
	input logic signed [31:0] imag_part,
	input logic signed [31:0] vertex_x,
	input logic signed [31:0] vertex_y,
	input logic               saturated
);

	// a pending result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// zero a gives an all-zero result
	a_azero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_AZERO |-> root_plus == 0 && root_minus == 0 &&
		imag_part == 0 && vertex_x == 0 && vertex_y == 0 && !saturated)
		else $error("nonzero fields for zero a");

	// complex pair has no second root
	a_cplx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_COMPLEX |-> root_minus == 0)
		else $error("complex pair with nonzero root_minus");

	// double root: equal roots, no imaginary part
	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_DOUBLE |-> root_plus == root_minus && imag_part == 0)
		else $error("double root mismatch");

	// distinct real roots carry no imaginary part
	a_two: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_kind == KIND_TWO |-> imag_part == 0)
		else $error("real roots with imaginary part");

endmodule

bind quadratic_root_vertex_solver qrvs_checker u_qrvs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.root_kind  (result.root_kind),
	.root_plus  (result.root_plus),
	.root_minus (result.root_minus),
	.imag_part  (result.imag_part),
	.vertex_x   (result.vertex_x),
	.vertex_y   (result.vertex_y),
	.saturated  (result.saturated)
);

/* tb/testbench.sv */
// testbench for the quadratic root and vertex solver: random and directed coefficient sets
module testbench;
	import qrvs_pkg::*;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} coef_set_t;

	typedef struct packed {
		logic        [1:0]  kind;
		logic signed [31:0] rp;
		logic signed [31:0] rm;
		logic signed [31:0] im;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               sat;
	} solution_t;

	localparam int FRAC = 16;
	localparam int LATENCY = 101;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   errors;
	longint cycle;
	bit   stim_done;
	bit   calm;
	int   hold_cycles;

	coef_set_t pending_sets[$];
	solution_t expected_solutions[$];

	qrvs_coef_if   coef();
	qrvs_result_if result();

	quadratic_root_vertex_solver #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef.sink),
		.result(result.source)
	);

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// saturate a wide signed value into q16.16
	function automatic logic signed [31:0] clip32(input logic signed [127:0] v,
			inout logic flag);
		if (v > 128'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// truncating fixed point division
	function automatic logic signed [127:0] fix_div(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic [127:0] nm;
		logic [127:0] dm;
		logic [127:0] q;
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		q = (nm << FRAC) / dm;
		return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
	endfunction

	// floor square root of a nonnegative value below 2^68
	function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] r;
		logic [127:0] t;
		r = 0;
		for (int bit_i = 33; bit_i >= 0; bit_i--) begin
			t = r | (128'd1 << bit_i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// roots and vertex of one coefficient set
	function automatic solution_t solve_quadratic(input coef_set_t s);
		solution_t o;
		logic signed [127:0] a, b, c, d, root, two_a, vx, rp, rm, im, vy, q;
		logic flag;
		a = s.a;
		b = s.b;
		c = s.c;
		o = '0;
		if (a == 0) begin
			o.kind = KIND_AZERO;
			return o;
		end
		flag = 1'b0;
		d = b * b - 4 * a * c;
		root = floor_sqrt(d < 0 ? -d : d);
		two_a = 2 * a;
		vx = fix_div(-b, two_a);
		if (d < 0) begin
			o.kind = KIND_COMPLEX;
			rp = vx;
			rm = 0;
			im = fix_div(root, two_a < 0 ? -two_a : two_a);
		end else begin
			o.kind = (d == 0) ? KIND_DOUBLE : KIND_TWO;
			rp = fix_div(-b + root, two_a);
			rm = fix_div(-b - root, two_a);
			im = 0;
		end
		q = (b * b) / (4 * (a < 0 ? -a : a));
		vy = c - (a > 0 ? q : -q);
		o.rp = clip32(rp, flag);
		o.rm = clip32(rm, flag);
		o.im = clip32(im, flag);
		o.vx = clip32(vx, flag);
		o.vy = clip32(vy, flag);
		o.sat = flag;
		return o;
	endfunction

	// random coefficient with biased magnitudes
	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 255)) - 128;
			2: return ($signed($urandom_range(0, 2047)) - 1024) <<< FRAC;
			3: return $signed($urandom_range(0, 131071)) - 65536;
			4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return ($signed($urandom_range(0, 65535)) - 32768) <<< 8;
		endcase
	endfunction

	// fill the request queue
	initial begin
		coef_set_t s;
		logic signed [31:0] k;
		logic signed [31:0] extremes[5];
		extremes = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd65536, -32'sd65536};
		// a is zero, double root, complex, tiny positive discriminant, extremes
		pending_sets.push_back('{32'sd0, 32'sd12345, -32'sd7});
		pending_sets.push_back('{32'sd65536, 32'sd131072, 32'sd65536});
		pending_sets.push_back('{32'sd65536, 32'sd0, 32'sd65536});
		pending_sets.push_back('{-32'sd65536, 32'sd0, -32'sd131072});
		pending_sets.push_back('{32'sd65536, -32'sd196608, 32'sd131072});
		pending_sets.push_back('{32'sd1, 32'sd1, 32'sd0});
		pending_sets.push_back('{32'sd3, 32'sd7, 32'sd4});
		pending_sets.push_back('{32'sd1, 32'sd0, 32'sd0});
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 3; j++) begin
				k = extremes[(i + j) % 5];
				pending_sets.push_back('{extremes[i], k, extremes[(i * 2 + j) % 5]});
			end
		// random sets, a share forced to double roots
		for (int i = 0; i < 1750; i++) begin
			s.a = rand_coef();
			s.b = rand_coef();
			s.c = rand_coef();
			if ($urandom_range(0, 9) == 0) begin
				k = $signed($urandom_range(0, 2047)) - 1024;
				s.a = 1;
				s.b = 2 * k;
				s.c = k * k;
			end
			pending_sets.push_back(s);
		end
	end

	// reset, then the end of run
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && expected_solutions.size() == 0))
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		cycle = 0;
		errors = 0;
		stim_done = 1'b0;
		coef.valid = 1'b0;
		coef.coef_a = '0;
		coef.coef_b = '0;
		coef.coef_c = '0;
		result.ready = 1'b0;
	end

	// calm stretch with no idling, mid run
	always @(posedge clk)
		calm <= (cycle > 800 && cycle < 1400);

	// request driver
	always @(posedge clk) begin
		coef_set_t s;
		if (arst_n) begin
			if (coef.valid && coef.ready) begin
				expected_solutions.push_back(solve_quadratic('{coef.coef_a, coef.coef_b,
					coef.coef_c}));
			end
			if (!coef.valid || coef.ready) begin
				if (pending_sets.size() > 0 && (calm || $urandom_range(0, 99) >= 25)) begin
					s = pending_sets.pop_front();
					coef.valid <= 1'b1;
					coef.coef_a <= s.a;
					coef.coef_b <= s.b;
					coef.coef_c <= s.c;
				end else begin
					coef.valid <= 1'b0;
					if (pending_sets.size() == 0)
						stim_done <= 1'b1;
				end
			end
		end
	end

	// hold-off counter for the long receiver stall
	always @(posedge clk) begin
		if (!arst_n)
			hold_cycles <= 0;
		else if (hold_cycles < 400)
			hold_cycles <= hold_cycles + 1;
	end

	// result monitor with a long hold-off early on
	always @(posedge clk) begin
		solution_t e;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_solutions.size() == 0) begin
					$error("result with no request pending");
					errors = errors + 1;
				end else begin
					e = expected_solutions.pop_front();
					if (result.root_kind !== e.kind) begin
						$error("root_kind exp %0d got %0d", e.kind, result.root_kind);
						errors = errors + 1;
					end
					if (result.root_plus !== e.rp) begin
						$error("root_plus exp %0d got %0d", e.rp, result.root_plus);
						errors = errors + 1;
					end
					if (result.root_minus !== e.rm) begin
						$error("root_minus exp %0d got %0d", e.rm, result.root_minus);
						errors = errors + 1;
					end
					if (result.imag_part !== e.im) begin
						$error("imag_part exp %0d got %0d", e.im, result.imag_part);
						errors = errors + 1;
					end
					if (result.vertex_x !== e.vx) begin
						$error("vertex_x exp %0d got %0d", e.vx, result.vertex_x);
						errors = errors + 1;
					end
					if (result.vertex_y !== e.vy) begin
						$error("vertex_y exp %0d got %0d", e.vy, result.vertex_y);
						errors = errors + 1;
					end
					if (result.saturated !== e.sat) begin
						$error("saturated exp %0d got %0d", e.sat, result.saturated);
						errors = errors + 1;
					end
				end
			end
			if (hold_cycles >= 150 && hold_cycles < 400)
				result.ready <= 1'b0;
			else
				result.ready <= calm || $urandom_range(0, 99) >= 25;
		end
	end

endmodule

/* files.f */
rtl/qrvs_pkg.sv
rtl/qrvs_coef_if.sv
rtl/qrvs_result_if.sv
rtl/qrvs_sqrt_cell.sv
rtl/qrvs_div_cell.sv
rtl/quadratic_root_vertex_solver.sv
rtl/qrvs_checker.sv
tb/testbench.sv
